[design/hdlctx_pkg.sv]
// ----------------------------------------------------------------------------
// hdlctx_pkg
// Shared constants and types for the HDLC transmit framer: flag pattern,
// stuffing run length, CRC-16 polynomial and the control bundles between
// the sequencer, the CRC unit and the line packer.
// ----------------------------------------------------------------------------
package hdlctx_pkg;

   localparam logic [7:0]  FLAG_BYTE      = 8'h7E;
   localparam logic [2:0]  STUFF_RUN_LAST = 3'd4;    // fifth one in a row
   localparam logic [15:0] CRC_POLY       = 16'h1021;
   localparam logic [15:0] CRC_INIT       = 16'hFFFF;
   localparam logic [5:0]  PREAMBLE_RESET = 6'd8;

   typedef enum logic [1:0] {
      CRC_HOLD,
      CRC_LOAD,
      CRC_FEED,
      CRC_SHIFT
   } crc_op_type;

   typedef struct packed {
      logic clear;       // restart line level and packer at a start command
      logic bit_en;      // one line bit this cycle
      logic bit_val;     // raw bit before nrzi
      logic flush;       // end of item: release the held byte as last result
      logic frame_end;   // flush belongs to the final byte of a frame
   } line_ctl_type;

   typedef struct packed {
      logic       ready;    // output slot can take a byte this cycle
      logic [2:0] fill;     // line bits in the partial byte
   } line_sts_type;

endpackage

[design/hdlctx_crc.sv]
// ----------------------------------------------------------------------------
// hdlctx_crc
// Bit-serial CRC-16 register: loads all ones, feeds one data bit per cycle
// while op is CRC_FEED and shifts the value out high bit first for the FCS.
// ----------------------------------------------------------------------------
module hdlctx_crc (
   input  logic                   clock,
   input  logic                   reset,
   input  hdlctx_pkg::crc_op_type op,
   input  logic                   bit_val,
   output logic                   crc_msb
);
   import hdlctx_pkg::*;

   logic [15:0] crc_ff;
   logic [15:0] crc_in;

   always_comb begin
      case (op)
         CRC_LOAD:  crc_in = CRC_INIT;
         CRC_FEED:  crc_in = {crc_ff[14:0], 1'b0} ^ ((crc_ff[15] ^ bit_val) ? CRC_POLY : 16'h0);
         CRC_SHIFT: crc_in = {crc_ff[14:0], 1'b0};
         default:   crc_in = crc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_INIT;
      end else begin
         crc_ff <= crc_in;
      end
   end

   assign crc_msb = crc_ff[15];

endmodule

[design/hdlctx_line.sv]
// ----------------------------------------------------------------------------
// hdlctx_line
// NRZI encoder and byte packer. Each line bit toggles or keeps the level and
// is shifted into a byte. A finished byte is held back until the next one
// completes or the item ends, so the last result of an item can be marked.
// ----------------------------------------------------------------------------
module hdlctx_line (
   input  logic                     clock,
   input  logic                     reset,
   input  hdlctx_pkg::line_ctl_type ctl,
   output hdlctx_pkg::line_sts_type sts,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_line_byte,
   output logic                     rsp_run_last,
   output logic                     rsp_frame_done
);
   import hdlctx_pkg::*;

   logic       level_ff, level_in;
   logic [6:0] acc_ff, acc_in;
   logic [2:0] fill_ff, fill_in;
   logic       pend_valid_ff, pend_valid_in;
   logic [7:0] pend_byte_ff, pend_byte_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_last_ff, out_last_in;
   logic       out_done_ff, out_done_in;
   logic       new_level;
   logic       out_load;

   assign sts.ready = !out_valid_ff || !rsp_stall;
   assign sts.fill  = fill_ff;
   assign new_level = ctl.bit_val ? level_ff : !level_ff;

   always_comb begin
      level_in      = level_ff;
      acc_in        = acc_ff;
      fill_in       = fill_ff;
      pend_valid_in = pend_valid_ff;
      pend_byte_in  = pend_byte_ff;
      out_byte_in   = out_byte_ff;
      out_last_in   = out_last_ff;
      out_done_in   = out_done_ff;
      out_load      = 1'b0;
      if (ctl.clear) begin
         level_in = 1'b0;
         acc_in   = '0;
         fill_in  = '0;
      end else if (ctl.bit_en) begin
         level_in = new_level;
         if (fill_ff == 3'd7) begin
            // byte complete: push the held byte on, hold the new one
            if (pend_valid_ff) begin
               out_load    = 1'b1;
               out_byte_in = pend_byte_ff;
               out_last_in = 1'b0;
               out_done_in = 1'b0;
            end
            pend_valid_in = 1'b1;
            pend_byte_in  = {acc_ff, new_level};
            acc_in        = '0;
            fill_in       = '0;
         end else begin
            acc_in  = {acc_ff[5:0], new_level};
            fill_in = fill_ff + 3'd1;
         end
      end else if (ctl.flush) begin
         if (pend_valid_ff) begin
            out_load    = 1'b1;
            out_byte_in = pend_byte_ff;
            out_last_in = 1'b1;
            out_done_in = ctl.frame_end;
         end
         pend_valid_in = 1'b0;
      end
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff      <= 1'b0;
         acc_ff        <= '0;
         fill_ff       <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         level_ff      <= level_in;
         acc_ff        <= acc_in;
         fill_ff       <= fill_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      pend_byte_ff <= pend_byte_in;
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
      out_done_ff  <= out_done_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_line_byte  = out_byte_ff;
   assign rsp_run_last   = out_last_ff;
   assign rsp_frame_done = out_done_ff;

endmodule

[design/hdlc_transmit_framer_top.sv]
// ----------------------------------------------------------------------------
// hdlc_transmit_framer_top
// HDLC transmit framer: preamble and flags, CRC-16 FCS, bit stuffing, NRZI,
// line bits packed MSB first into bytes.
// ----------------------------------------------------------------------------
// Usage: a transfer on req_ with req_command = 0 starts a frame and sends
// the preamble count + 1 flag bytes. Each req_command = 1 transfer sends one
// frame byte LSB first, bit stuffed; with req_last_byte set it also sends the
// FCS, the end flag and zero padding to a byte boundary. Results leave on
// rsp_ one line byte per transfer; rsp_run_last marks the last byte caused by
// a request and rsp_frame_done the padded final byte of a frame.
// Timing: a sequencer drives one line bit per cycle through the shared NRZI
// packer, plus a flush step to close the item. A data byte carries up to two
// stuffed zeros. The sequencer returns to idle before the next transfer.
// req_stall stays high while an item is in progress. When rsp_stall holds a
// byte in the output register the bit sequencer pauses until it is taken.
// Reset clears the sequencer, stuffing run and NRZI level, loads the CRC with
// all ones and sets the preamble count to 8. The user must make csr_ writes
// only while no item is in progress; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module hdlc_transmit_framer_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_command,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_line_byte,
   output logic       rsp_run_last,
   output logic       rsp_frame_done,
   input  logic       csr_wr_en,
   input  logic [5:0] csr_wr_data
);
   import hdlctx_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FLAG,
      ST_DATA,
      ST_FCS,
      ST_EFLAG,
      ST_PAD,
      ST_FLUSH
   } state_type;

   state_type    state_ff, state_in;
   logic [3:0]   cnt_ff, cnt_in;
   logic [5:0]   flag_cnt_ff, flag_cnt_in;
   logic [5:0]   preamble_ff, preamble_in;
   logic [7:0]   data_ff, data_in;
   logic         last_ff, last_in;
   logic         stuff_ff, stuff_in;
   logic [2:0]   ones_ff, ones_in;
   crc_op_type   crc_op;
   logic         crc_bit;
   logic         crc_msb;
   line_ctl_type line_ctl;
   line_sts_type line_sts;
   logic         accept;
   logic         go;
   logic         sbit;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign go        = line_sts.ready;

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      flag_cnt_in = flag_cnt_ff;
      preamble_in = csr_wr_en ? csr_wr_data : preamble_ff;
      data_in     = data_ff;
      last_in     = last_ff;
      stuff_in    = stuff_ff;
      ones_in     = ones_ff;
      crc_op      = CRC_HOLD;
      crc_bit     = 1'b0;
      line_ctl    = '0;
      sbit        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cnt_in  = '0;
               data_in = req_data_byte;
               if (!req_command) begin
                  line_ctl.clear = 1'b1;
                  crc_op         = CRC_LOAD;
                  ones_in        = '0;
                  stuff_in       = 1'b0;
                  last_in        = 1'b0;
                  flag_cnt_in    = preamble_ff;
                  state_in       = ST_FLAG;
               end else begin
                  last_in  = req_last_byte;
                  state_in = ST_DATA;
               end
            end
         end
         ST_FLAG: begin
            if (go) begin
               line_ctl.bit_en  = 1'b1;
               line_ctl.bit_val = FLAG_BYTE[~cnt_ff[2:0]];
               cnt_in           = cnt_ff + 4'd1;
               if (cnt_ff[2:0] == 3'd7) begin
                  cnt_in = '0;
                  if (flag_cnt_ff == '0) begin
                     state_in = ST_FLUSH;
                  end else begin
                     flag_cnt_in = flag_cnt_ff - 6'd1;
                  end
               end
            end
         end
         ST_DATA, ST_FCS: begin
            if (go) begin
               line_ctl.bit_en = 1'b1;
               if (stuff_ff) begin
                  line_ctl.bit_val = 1'b0;
                  stuff_in         = 1'b0;
               end else begin
                  if (state_ff == ST_DATA) begin
                     sbit    = data_ff[cnt_ff[2:0]];
                     crc_op  = CRC_FEED;
                     crc_bit = sbit;
                  end else begin
                     sbit   = !crc_msb;
                     crc_op = CRC_SHIFT;
                  end
                  line_ctl.bit_val = sbit;
                  if (sbit) begin
                     if (ones_ff == STUFF_RUN_LAST) begin
                        stuff_in = 1'b1;
                        ones_in  = '0;
                     end else begin
                        ones_in = ones_ff + 3'd1;
                     end
                  end else begin
                     ones_in = '0;
                  end
                  cnt_in = cnt_ff + 4'd1;
                  if (state_ff == ST_DATA && cnt_ff[2:0] == 3'd7) begin
                     cnt_in   = '0;
                     state_in = last_ff ? ST_FCS : ST_FLUSH;
                  end else if (state_ff == ST_FCS && cnt_ff == 4'd15) begin
                     cnt_in   = '0;
                     state_in = ST_EFLAG;
                  end
               end
            end
         end
         ST_EFLAG: begin
            if (go) begin
               line_ctl.bit_en = 1'b1;
               if (stuff_ff) begin
                  line_ctl.bit_val = 1'b0;
                  stuff_in         = 1'b0;
               end else begin
                  line_ctl.bit_val = FLAG_BYTE[~cnt_ff[2:0]];
                  cnt_in           = cnt_ff + 4'd1;
                  if (cnt_ff[2:0] == 3'd7) begin
                     cnt_in   = '0;
                     crc_op   = CRC_LOAD;
                     ones_in  = '0;
                     state_in = ST_PAD;
                  end
               end
            end
         end
         ST_PAD: begin
            if (line_sts.fill == '0) begin
               state_in = ST_FLUSH;
            end else if (go) begin
               line_ctl.bit_en  = 1'b1;
               line_ctl.bit_val = 1'b0;
            end
         end
         ST_FLUSH: begin
            if (go) begin
               if (stuff_ff) begin
                  // stuffed zero after the last bit of a plain data byte
                  line_ctl.bit_en  = 1'b1;
                  line_ctl.bit_val = 1'b0;
                  stuff_in         = 1'b0;
               end else begin
                  line_ctl.flush     = 1'b1;
                  line_ctl.frame_end = last_ff;
                  state_in           = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cnt_ff      <= '0;
         flag_cnt_ff <= '0;
         preamble_ff <= PREAMBLE_RESET;
         last_ff     <= 1'b0;
         stuff_ff    <= 1'b0;
         ones_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         flag_cnt_ff <= flag_cnt_in;
         preamble_ff <= preamble_in;
         last_ff     <= last_in;
         stuff_ff    <= stuff_in;
         ones_ff     <= ones_in;
      end
      data_ff <= data_in;
   end

   hdlctx_crc u_crc (
      .clock   (clock),
      .reset   (reset),
      .op      (crc_op),
      .bit_val (crc_bit),
      .crc_msb (crc_msb)
   );

   hdlctx_line u_line (
      .clock          (clock),
      .reset          (reset),
      .ctl            (line_ctl),
      .sts            (line_sts),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_line_byte  (rsp_line_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_frame_done (rsp_frame_done)
   );

endmodule
